FILE: design/gpio_lb_pkg.sv
package gpio_lb_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OFS_W  = 8;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [OFS_W-1:0]  ofs_t;

  // bus access kind
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // register map
  localparam ofs_t OFS_DIR   = 8'h4C;
  localparam ofs_t OFS_DIN   = 8'h50;
  localparam ofs_t OFS_DOUT  = 8'h54;
  localparam ofs_t OFS_DSET  = 8'h58;
  localparam ofs_t OFS_DCLR  = 8'h5C;
  localparam ofs_t OFS_SEL   = 8'h8C;
  localparam ofs_t OFS_LBCTL = 8'h90;
  localparam ofs_t OFS_DIS   = 8'h94;

  localparam logic [3:0] LOOP_EN_CODE  = 4'hA;
  localparam word_t      LBCTL_RESET   = 32'h0005_0000;
  // fill bit of a split pair, indexed by {loopback control bit i, bit 2i+1, 0}
  localparam logic [7:0] PAIR_PATTERN  = 8'b0011_1100;
  localparam int unsigned MAX_PAIRS    = 16;

  typedef struct packed {
    logic  action;
    ofs_t  reg_offset;
    word_t write_data;
  } req_t;

endpackage

FILE: design/gpio_lb_if.sv
interface gpio_lb_in_if
  import gpio_lb_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic  action;
  ofs_t  reg_offset;
  word_t write_data;

  modport source (output valid, action, reg_offset, write_data, input ready);
  modport sink   (input valid, action, reg_offset, write_data, output ready);
endinterface

interface gpio_lb_out_if
  import gpio_lb_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t read_data;
  logic  bad_offset;

  modport source (output valid, read_data, bad_offset, input ready);
  modport sink   (input valid, read_data, bad_offset, output ready);
endinterface

FILE: design/gpio_port_with_pair_loopback.sv
// GPIO port register file with pair-wise loopback.
// Channels: in_req carries one bus request (action, reg_offset, write_data);
// out_rsp returns exactly one response per request (read_data, bad_offset),
// in request order. Both use valid/ready; a transfer happens when both high.
// Path: a request is held in the input register, then the register-file
// update and the response register are written together.
// Throughput: one request per cycle while out_rsp.ready is high; requests may
// follow back to back and a write is visible to the very next read.
// Stall: while out_rsp.ready is low the response holds; one further request
// is taken into the input register, after which in_req.ready drops until the
// response is taken.
// Reset (rst_n low, synchronous): both stages empty, direction, data-out and
// data-in cleared, loopback control set to 0x0005_0000 (loopback off).
// Loopback is on when control bits 19:16 read 0xA: data-in then mirrors
// data-out, each split pair resolved from bit 2i+1 (control bit i clear) or
// bit 2i (set).
module gpio_port_with_pair_loopback
  import gpio_lb_pkg::*;
#(
  parameter int unsigned PIN_PAIRS = 16
) (
  input logic         clk,
  input logic         rst_n,
  gpio_lb_in_if.sink    in_req,
  gpio_lb_out_if.source out_rsp
);

  logic  s1_valid_r;
  req_t  s1_req_r;
  logic  out_valid_r;
  word_t out_data_r;
  logic  out_bad_r;

  word_t dir_r,  dir_nxt;
  word_t dout_r, dout_nxt;
  word_t din_r,  din_nxt;
  word_t lbctl_r, lbctl_nxt;
  word_t rd_nxt;
  logic  bad_nxt;
  logic  refresh;
  word_t loop_val;

  logic s1_adv;
  logic in_acc;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign in_acc = in_req.valid && in_req.ready;

  // register file update and read data / bad-offset decode
  always_comb begin
    dir_nxt   = dir_r;
    dout_nxt  = dout_r;
    lbctl_nxt = lbctl_r;
    refresh   = 1'b0;
    rd_nxt    = '0;
    bad_nxt   = 1'b0;
    if (s1_req_r.action == ACT_WRITE) begin
      unique case (s1_req_r.reg_offset)
        OFS_SEL, OFS_DIS, OFS_DIN: ;
        OFS_DIR: begin
          dir_nxt = s1_req_r.write_data;
          refresh = 1'b1;
        end
        OFS_DOUT: begin
          dout_nxt = s1_req_r.write_data;
          refresh  = 1'b1;
        end
        OFS_DSET: begin
          dout_nxt = dout_r | s1_req_r.write_data;
          refresh  = 1'b1;
        end
        OFS_DCLR: begin
          dout_nxt = dout_r & ~s1_req_r.write_data;
          refresh  = 1'b1;
        end
        OFS_LBCTL: lbctl_nxt = s1_req_r.write_data;
        default:   bad_nxt = 1'b1;
      endcase
    end else begin
      unique case (s1_req_r.reg_offset)
        OFS_DIN:                     rd_nxt = din_r;
        OFS_DIR:                     rd_nxt = dir_r;
        OFS_DOUT, OFS_DSET, OFS_DCLR: rd_nxt = dout_r;
        OFS_LBCTL:                   rd_nxt = lbctl_r;
        OFS_SEL, OFS_DIS:            ;
        default:                     bad_nxt = 1'b1;
      endcase
    end
  end

  // loopback pair resolution on the new data-out
  always_comb begin
    logic [2:0] idx;
    loop_val = dout_nxt;
    for (int p = 0; p < PIN_PAIRS && p < MAX_PAIRS; p++) begin
      idx = {lbctl_r[p], dout_nxt[2*p+1], 1'b0};
      if (dout_nxt[2*p] != dout_nxt[2*p+1]) begin
        loop_val[2*p]   = PAIR_PATTERN[idx];
        loop_val[2*p+1] = PAIR_PATTERN[idx];
      end
    end
  end

  always_comb begin
    din_nxt = din_r;
    if (refresh) begin
      if (lbctl_r[19:16] == LOOP_EN_CODE) begin
        din_nxt = loop_val;
      end else begin
        din_nxt = (din_r & ~dir_nxt) | (dout_nxt & dir_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dir_r       <= '0;
      dout_r      <= '0;
      din_r       <= '0;
      lbctl_r     <= LBCTL_RESET;
    end else begin
      if (in_req.ready) begin
        s1_valid_r <= in_req.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        dir_r       <= dir_nxt;
        dout_r      <= dout_nxt;
        din_r       <= din_nxt;
        lbctl_r     <= lbctl_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.action     <= in_req.action;
      s1_req_r.reg_offset <= in_req.reg_offset;
      s1_req_r.write_data <= in_req.write_data;
    end
    if (s1_adv) begin
      out_data_r <= rd_nxt;
      out_bad_r  <= bad_nxt;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.read_data  = out_data_r;
  assign out_rsp.bad_offset = out_bad_r;

endmodule

FILE: design/gpio_lb_chk.sv
module gpio_lb_chk
  import gpio_lb_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_read_data,
  input logic  out_bad_offset
);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_bad_offset))
    else $error("response changed while stalled");

  // bad offset never returns data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_offset |-> out_read_data == '0)
    else $error("bad offset with non-zero read data");

  // reset empties the response stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

  // an empty response stage never back-pressures requests
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request stalled with empty response stage");

endmodule

bind gpio_port_with_pair_loopback gpio_lb_chk u_gpio_lb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_read_data (out_rsp.read_data),
  .out_bad_offset(out_rsp.bad_offset)
);
